/* hw/rtl/ptq_pkg.sv */
// ============================================================================
// ptq_pkg: periodic timer queue shared types and codes
// Mode and result codes, fixed field widths and the scan result bundle.
// ============================================================================
package ptq_pkg;

	localparam int TW = 32;   // time width
	localparam int IVW = 16;  // interval register width
	localparam int MW = 2;    // mode / kind width
	localparam int SW = 5;    // slot field width

	localparam logic [MW-1:0] MODE_ENROLL = 2'd0;
	localparam logic [MW-1:0] MODE_TICK   = 2'd1;
	localparam logic [MW-1:0] MODE_CLOSE  = 2'd2;

	localparam logic [MW-1:0] KIND_FIRE   = 2'd0;
	localparam logic [MW-1:0] KIND_ARM    = 2'd1;
	localparam logic [MW-1:0] KIND_DISARM = 2'd2;

	localparam logic [IVW-1:0] IV_RESET = 16'd100;

	// outcome of one pass over the table
	typedef struct packed {
		logic          found_skip;  // earliest entry outside the fired mask
		logic [TW-1:0] due_skip;
		logic          found_all;   // earliest entry overall
		logic [TW-1:0] due_all;
	} scan_res_t;

endpackage

/* hw/rtl/ptq_ram.sv */
// ============================================================================
// ptq_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ============================================================================
module ptq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/ptq_rem.sv */
// ============================================================================
// ptq_rem: iterative remainder unit
// Restoring division of a 32-bit value by a 16-bit divisor, one bit a cycle.
// ============================================================================
module ptq_rem (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [ptq_pkg::TW-1:0]   dividend,
	input  logic [ptq_pkg::IVW-1:0]  divisor,
	output logic                     done,
	output logic [ptq_pkg::IVW-1:0]  rem
);

	localparam int CW = $clog2(ptq_pkg::TW);

	logic                    busy_q;
	logic                    done_q;
	logic [CW-1:0]           cnt_q;
	logic [ptq_pkg::TW-1:0]  dvd_q;
	logic [ptq_pkg::IVW-1:0] dvs_q;
	logic [ptq_pkg::IVW-1:0] rem_q;
	logic [ptq_pkg::IVW:0]   trial;
	logic [ptq_pkg::IVW:0]   diff;

	assign trial = {rem_q, dvd_q[ptq_pkg::TW-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(ptq_pkg::TW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[ptq_pkg::TW-2:0], 1'b0};
			// remainder stays below divisor, so the top bit drops out
			rem_q <= (trial >= {1'b0, dvs_q}) ? diff[ptq_pkg::IVW-1:0]
			                                  : trial[ptq_pkg::IVW-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

/* hw/rtl/ptq_scan.sv */
// ============================================================================
// ptq_scan: earliest-entry search over the due-time RAM
// Walks every slot once, keeping the minimum with and without the skip mask.
// ============================================================================
module ptq_scan #(
	parameter int SLOTS = 32,
	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [SLOTS-1:0]       occ,
	input  logic [SLOTS-1:0]       skip,
	output logic [IW-1:0]          raddr,
	input  logic [ptq_pkg::TW-1:0] rdata,
	output logic                   done,
	output ptq_pkg::scan_res_t     res,
	output logic [IW-1:0]          best_idx
);

	logic                   busy_q;
	logic [IW-1:0]          cnt_q;
	logic                   vld_s1;
	logic                   last_s1;
	logic [IW-1:0]          idx_s1;
	logic                   done_q;
	logic                   found_skip_q;
	logic [ptq_pkg::TW-1:0] due_skip_q;
	logic                   found_all_q;
	logic [ptq_pkg::TW-1:0] due_all_q;
	logic [IW-1:0]          best_q;
	logic                   cnt_last;
	logic                   take_skip;
	logic                   take_all;

	assign cnt_last = (cnt_q == IW'(SLOTS - 1));
	assign raddr    = cnt_q;

	assign take_skip = vld_s1 && occ[idx_s1] && !skip[idx_s1] &&
	                   (!found_skip_q || (rdata < due_skip_q));
	assign take_all  = vld_s1 && occ[idx_s1] &&
	                   (!found_all_q || (rdata < due_all_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			cnt_q        <= '0;
			vld_s1       <= 1'b0;
			last_s1      <= 1'b0;
			done_q       <= 1'b0;
			found_skip_q <= 1'b0;
			found_all_q  <= 1'b0;
		end else begin
			vld_s1  <= busy_q;
			last_s1 <= busy_q && cnt_last;
			done_q  <= vld_s1 && last_s1;
			if (start) begin
				busy_q       <= 1'b1;
				cnt_q        <= '0;
				found_skip_q <= 1'b0;
				found_all_q  <= 1'b0;
			end else begin
				if (busy_q) begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_last) begin
						busy_q <= 1'b0;
					end
				end
				if (take_skip) begin
					found_skip_q <= 1'b1;
				end
				if (take_all) begin
					found_all_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
		if (!start && take_skip) begin
			due_skip_q <= rdata;
			best_q     <= idx_s1;
		end
		if (!start && take_all) begin
			due_all_q <= rdata;
		end
	end

	assign done     = done_q;
	assign res      = {found_skip_q, due_skip_q, found_all_q, due_all_q};
	assign best_idx = best_q;

endmodule

/* hw/rtl/periodic_timer_queue_unit.sv */
// ============================================================================
// periodic_timer_queue_unit: periodic timer table with earliest-due search
// Enroll, close and tick commands over a RAM of due times; ticks fire every
// live due entry in due order and re-arm it by the flush interval.
// ============================================================================
// Sequence: close gives no result. Enroll runs one table pass, then gives
//   its arm or disarm result. Tick runs a table pass per fired entry and
//   per dropped entry, then a final pass, and the bit-serial remainder for
//   each fired entry that is more than one interval late; output stalls
//   can hold any result.
// Throughput: one item at a time; the RAM scan loop sets the rate.
// Reset: arst_n clears occupied/live marks and control, sets interval (100);
//   the due-time RAM is not cleared, only occupied entries are ever used.
// ============================================================================
module periodic_timer_queue_unit #(
	parameter int SLOTS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration: flush interval in ms
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ptq_pkg::IVW-1:0]       cfg_data,
	// command channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [ptq_pkg::MW-1:0]        mode,
	input  logic [ptq_pkg::SW-1:0]        slot,
	input  logic [ptq_pkg::TW-1:0]        time_ms,
	input  logic [ptq_pkg::TW-1:0]        now_ms,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [ptq_pkg::MW-1:0]        kind,
	output logic [ptq_pkg::SW-1:0]        fired_slot,
	output logic [ptq_pkg::TW-1:0]        wake_ms,
	output logic                          last
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int TW = ptq_pkg::TW;

	// sequencer states
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;  // table pass running
	localparam logic [2:0] ST_DECIDE = 3'd2;  // act on pass result
	localparam logic [2:0] ST_DIV    = 3'd3;  // lateness remainder
	localparam logic [2:0] ST_WB     = 3'd4;  // write re-armed due time

	logic [2:0]                state_q;
	logic [ptq_pkg::IVW-1:0]   iv_q;
	logic [SLOTS-1:0]          occ_q;
	logic [SLOTS-1:0]          live_q;
	logic [SLOTS-1:0]          fired_q;

	// latched command
	logic                      tick_q;
	logic [TW-1:0]             t_q;
	logic [TW-1:0]             now_q;

	// entry being re-armed
	logic [IW-1:0]             e_q;
	logic [TW-1:0]             diff_q;
	logic [TW:0]               nxt_q;
	logic                      scan_start_q;
	logic                      div_start_q;

	// output register
	logic                      out_valid_q;
	logic [ptq_pkg::MW-1:0]    kind_q;
	logic [ptq_pkg::SW-1:0]    fired_slot_q;
	logic [TW-1:0]             delay_q;
	logic                      last_q;

	// RAM / unit interconnect
	logic                      ram_we;
	logic [IW-1:0]             ram_waddr;
	logic [TW-1:0]             ram_wdata;
	logic [IW-1:0]             ram_raddr;
	logic [TW-1:0]             ram_rdata;
	logic                      scan_done;
	ptq_pkg::scan_res_t        scan_res;
	logic [IW-1:0]             best_idx;
	logic                      rem_done;
	logic [ptq_pkg::IVW-1:0]   rem;

	logic                      in_xfer;
	logic                      out_free;
	logic                      slot_ok;
	logic [IW-1:0]             slot_idx;
	logic [ptq_pkg::IVW-1:0]   iv_eff;
	logic                      hit;
	logic [TW-1:0]             late;
	logic [TW:0]               nxt_fast;
	logic [TW:0]               nxt_slow;
	logic [TW-1:0]             nxt_sat;
	logic [TW-1:0]             arm_delay;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	assign slot_ok  = ({2'b00, slot} < 7'(SLOTS));
	assign slot_idx = IW'(slot);
	assign iv_eff   = (iv_q == '0) ? ptq_pkg::IVW'(1) : iv_q;

	// earliest unfired entry is due at or before the tick time
	assign hit  = tick_q && scan_res.found_skip && (scan_res.due_skip <= t_q);
	assign late = t_q - scan_res.due_skip;

	// next due = due + iv when less than one interval late,
	// otherwise t - ((t - due) mod iv) + iv
	assign nxt_fast = {1'b0, scan_res.due_skip} + {{(TW + 1 - ptq_pkg::IVW){1'b0}}, iv_eff};
	assign nxt_slow = {1'b0, t_q} - {{(TW + 1 - ptq_pkg::IVW){1'b0}}, rem}
	                + {{(TW + 1 - ptq_pkg::IVW){1'b0}}, iv_eff};
	assign nxt_sat  = nxt_q[TW] ? {TW{1'b1}} : nxt_q[TW-1:0];

	assign arm_delay = (scan_res.due_all > now_q) ? (scan_res.due_all - now_q)
	                                              : TW'(1);

	// RAM write: enroll at transfer, re-arm in write-back
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = slot_idx;
		ram_wdata = time_ms;
		if (state_q == ST_WB) begin
			ram_we    = 1'b1;
			ram_waddr = e_q;
			ram_wdata = nxt_sat;
		end else if (in_xfer && (mode == ptq_pkg::MODE_ENROLL) && slot_ok) begin
			ram_we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			iv_q         <= ptq_pkg::IV_RESET;
			occ_q        <= '0;
			live_q       <= '0;
			fired_q      <= '0;
			scan_start_q <= 1'b0;
			div_start_q  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			scan_start_q <= 1'b0;
			div_start_q  <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				iv_q <= cfg_data;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						fired_q <= '0;
						case (mode)
							ptq_pkg::MODE_ENROLL: begin
								if (slot_ok) begin
									occ_q[slot_idx]  <= 1'b1;
									live_q[slot_idx] <= 1'b1;
								end
								scan_start_q <= 1'b1;
								state_q      <= ST_SCAN;
							end
							ptq_pkg::MODE_TICK: begin
								scan_start_q <= 1'b1;
								state_q      <= ST_SCAN;
							end
							ptq_pkg::MODE_CLOSE: begin
								if (slot_ok) begin
									live_q[slot_idx] <= 1'b0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (!hit) begin
						// final arm / disarm transfer
						if (out_free) begin
							out_valid_q <= 1'b1;
							state_q     <= ST_IDLE;
						end
					end else if (!live_q[best_idx]) begin
						// closed entry: drop and search again
						occ_q[best_idx] <= 1'b0;
						scan_start_q    <= 1'b1;
						state_q         <= ST_SCAN;
					end else if (out_free) begin
						out_valid_q       <= 1'b1;
						fired_q[best_idx] <= 1'b1;
						if (late < TW'(iv_eff)) begin
							state_q <= ST_WB;
						end else begin
							div_start_q <= 1'b1;
							state_q     <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (rem_done) begin
						state_q <= ST_WB;
					end
				end
				ST_WB: begin
					scan_start_q <= 1'b1;
					state_q      <= ST_SCAN;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// command and re-arm datapath
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			tick_q <= (mode == ptq_pkg::MODE_TICK);
			t_q    <= time_ms;
			now_q  <= now_ms;
		end
		if ((state_q == ST_DECIDE) && hit && live_q[best_idx] && out_free) begin
			e_q    <= best_idx;
			diff_q <= late;
			nxt_q  <= nxt_fast;
		end
		if ((state_q == ST_DIV) && rem_done) begin
			nxt_q <= nxt_slow;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if ((state_q == ST_DECIDE) && out_free) begin
			if (!hit) begin
				kind_q       <= scan_res.found_all ? ptq_pkg::KIND_ARM
				                                   : ptq_pkg::KIND_DISARM;
				fired_slot_q <= '0;
				delay_q      <= scan_res.found_all ? arm_delay : '0;
				last_q       <= 1'b1;
			end else if (live_q[best_idx]) begin
				kind_q       <= ptq_pkg::KIND_FIRE;
				fired_slot_q <= ptq_pkg::SW'(best_idx);
				delay_q      <= '0;
				last_q       <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign fired_slot = fired_slot_q;
	assign wake_ms    = delay_q;
	assign last       = last_q;

	ptq_ram #(
		.WIDTH(TW),
		.DEPTH(SLOTS)
	) u_due_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	ptq_scan #(
		.SLOTS(SLOTS)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (scan_start_q),
		.occ     (occ_q),
		.skip    (fired_q),
		.raddr   (ram_raddr),
		.rdata   (ram_rdata),
		.done    (scan_done),
		.res     (scan_res),
		.best_idx(best_idx)
	);

	ptq_rem u_rem (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start_q),
		.dividend(diff_q),
		.divisor (iv_eff),
		.done    (rem_done),
		.rem     (rem)
	);

endmodule
